/* hdl/dgsp_pkg.sv */
`default_nettype none

package dgsp_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned SYNC_W     = 17;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [PHASE_W-1:0] PHASE_HALF = 16'h8000;

  // Output queue; its depth bounds the items in flight.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  // Packed so that left lands in the lowest bits of the output stream word.
  typedef struct packed {
    logic        [SYNC_W-1:0]   sync;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* hdl/dgsp_store.sv */
`default_nettype none

module dgsp_store #(
  parameter int unsigned RECORD_LEN = 88200
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      wr_en_i,
  input  wire        [$clog2(RECORD_LEN)-1:0]      wr_addr_i,
  input  wire signed [dgsp_pkg::SAMPLE_W-1:0]      wr_data_i,
  input  wire        [$clog2(RECORD_LEN)-1:0]      rd_addr_a_i,
  input  wire        [$clog2(RECORD_LEN)-1:0]      rd_addr_b_i,
  output logic signed [dgsp_pkg::SAMPLE_W-1:0]     rd_data_a_o,
  output logic signed [dgsp_pkg::SAMPLE_W-1:0]     rd_data_b_o
);
  import dgsp_pkg::*;

  localparam int unsigned PW = $clog2(RECORD_LEN + 1);

  logic signed [SAMPLE_W-1:0] mem [RECORD_LEN];
  logic signed [SAMPLE_W-1:0] rd_a_q, rd_b_q;
  logic                       hit_a_q, hit_b_q;
  logic [PW-1:0]              hw_q, hw_d;

  // Writes always run upward from address zero, so every entry below the
  // high-water mark has been written and everything at or above it reads
  // as zero.
  always_comb begin
    hw_d = hw_q;
    if (wr_en_i && (PW'(wr_addr_i) >= hw_q)) begin
      hw_d = PW'(wr_addr_i) + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
    end else begin
      hw_q <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q  <= mem[rd_addr_a_i];
    rd_b_q  <= mem[rd_addr_b_i];
    hit_a_q <= (PW'(rd_addr_a_i) < hw_q);
    hit_b_q <= (PW'(rd_addr_b_i) < hw_q);
  end

  assign rd_data_a_o = hit_a_q ? rd_a_q : '0;
  assign rd_data_b_o = hit_b_q ? rd_b_q : '0;

endmodule

`default_nettype wire

/* hdl/dgsp_window.sv */
`default_nettype none

module dgsp_window #(
  parameter int unsigned GRAIN_LEN = 4096
) (
  input  wire                               clk_i,
  input  wire  [$clog2(GRAIN_LEN)-1:0]      idx_a_i,
  input  wire  [$clog2(GRAIN_LEN)-1:0]      idx_b_i,
  output logic [dgsp_pkg::WIN_W-1:0]        win_a_o,
  output logic [dgsp_pkg::WIN_W-1:0]        win_b_o
);
  import dgsp_pkg::*;

  localparam logic [63:0] PiQ30 = 64'd3373259426;
  localparam int unsigned TaylorSteps = 12;
  localparam logic [63:0] TaylorDiv [TaylorSteps] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // Q2.30 Taylor series of sin on the angle folded into the first quarter.
  // Terms that have reached zero stay zero, so a fixed step count suffices.
  function automatic logic [WIN_W-1:0] half_sine(input int unsigned a);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    r = 64'(a);
    if (2 * r > GRAIN_LEN) begin
      r = GRAIN_LEN - r;
    end
    x  = (PiQ30 * r) / GRAIN_LEN;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    for (int k = 0; k < TaylorSteps; k++) begin
      t = ((t * x2) >> 30) / TaylorDiv[k];
      if (k % 2 == 0) begin
        s = s - t;
      end else begin
        s = s + t;
      end
    end
    s = (s + 64'd8192) >> 14;
    if (s > 64'd65535) begin
      s = 64'd65535;
    end
    return s[WIN_W-1:0];
  endfunction

  logic [WIN_W-1:0] win_rom [GRAIN_LEN];

  // The window ROM is filled once at start-up and never written afterwards.
  initial begin
    for (int i = 0; i < GRAIN_LEN; i++) begin
      win_rom[i] = half_sine(i);
    end
  end

  logic [WIN_W-1:0] win_a_q, win_b_q;

  always_ff @(posedge clk_i) begin
    win_a_q <= win_rom[idx_a_i];
    win_b_q <= win_rom[idx_b_i];
  end

  assign win_a_o = win_a_q;
  assign win_b_o = win_b_q;

endmodule

`default_nettype wire

/* hdl/dgsp_out_fifo.sv */
`default_nettype none

module dgsp_out_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  wire dgsp_pkg::result_t  push_data_i,
  input  wire                     pop_i,
  output dgsp_pkg::result_t       head_o,
  output dgsp_pkg::fifo_stat_t    stat_o
);
  import dgsp_pkg::*;

  result_t              slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + FIFO_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + FIFO_AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (FIFO_AW + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = slots[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));

endmodule

`default_nettype wire

/* hdl/dual_grain_sampler_player.sv */
`default_nettype none

// Two-grain granular sampler. A start item (tuser high) rearms recording
// at address zero and gives no result; every audio tick gives exactly one
// result. While recording, ticks store audio_in in a RECORD_LEN-entry
// sample RAM, output silence and report the advanced write pointer on
// sync; after RECORD_LEN ticks the block plays. A playing tick scales
// main_phase into a start index (reported on sync) and grain_phase into
// two grain offsets half a period apart; each grain latches the start
// index when its offset wraps and reads the RAM at start plus offset,
// weighted by a GRAIN_LEN-entry half-sine window ROM. One item is taken
// every cycle while the output queue has room; a result passes in turn
// through the input register, the grain state update, the RAM and ROM
// read and the output queue before it can be taken.
// The RAM has one write and two read ports; the output queue holds eight
// results, and input is held off only while eight items are in flight
// or waiting to be taken. No clearing pass is needed after reset: a
// high-water mark makes never-written entries read as zero.
module dual_grain_sampler_player #(
  parameter int unsigned RECORD_LEN = 88200,
  parameter int unsigned GRAIN_LEN  = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // audio_in [23:0], main_phase [39:24], grain_phase [55:40]
  input  wire  [dgsp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // kind
  input  wire                                s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // left_out [23:0], right_out [47:24], sync_out [64:48], zeros [71:65]
  output logic [dgsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import dgsp_pkg::*;

  localparam int unsigned AW = $clog2(RECORD_LEN);
  localparam int unsigned PW = $clog2(RECORD_LEN + 1);
  localparam int unsigned OW = $clog2(GRAIN_LEN);
  localparam int unsigned GW = $clog2(GRAIN_LEN + 1);
  localparam int unsigned CW = FIFO_AW + 1;
  localparam logic [PW-1:0] RecLenP = PW'(RECORD_LEN);
  localparam logic [AW:0]   RecLenS = (AW + 1)'(RECORD_LEN);

  // ---------------- accept: phase scaling ----------------
  logic                       accept;
  logic [SAMPLE_W-1:0]        in_audio;
  logic [PHASE_W-1:0]         in_main, in_grain, in_grain_b;
  logic [PHASE_W+PW-1:0]      start_prod;
  logic [PHASE_W+GW-1:0]      oa_prod, ob_prod;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_audio   = s_axis_tdata_i[SAMPLE_W-1:0];
  assign in_main    = s_axis_tdata_i[SAMPLE_W +: PHASE_W];
  assign in_grain   = s_axis_tdata_i[SAMPLE_W+PHASE_W +: PHASE_W];
  assign in_grain_b = in_grain + PHASE_HALF;
  assign start_prod = (PHASE_W + PW)'(in_main) * (PHASE_W + PW)'(RECORD_LEN);
  assign oa_prod    = (PHASE_W + GW)'(in_grain) * (PHASE_W + GW)'(GRAIN_LEN);
  assign ob_prod    = (PHASE_W + GW)'(in_grain_b) * (PHASE_W + GW)'(GRAIN_LEN);

  logic                       a_vld_q;
  kind_e                      a_kind_q;
  logic signed [SAMPLE_W-1:0] a_sample_q;
  logic [AW-1:0]              a_start_q;
  logic [OW-1:0]              a_oa_q, a_ob_q;

  always_ff @(posedge clk_i) begin
    a_kind_q   <= kind_e'(s_axis_tuser_i);
    a_sample_q <= in_audio;
    a_start_q  <= start_prod[PHASE_W +: AW];
    a_oa_q     <= oa_prod[PHASE_W +: OW];
    a_ob_q     <= ob_prod[PHASE_W +: OW];
  end

  // ---------------- state stage: recording and grain latches ----------------
  logic                rec_q, rec_d;
  logic [PW-1:0]       wp_q, wp_d, wp_inc;
  logic [OW-1:0]       prev_a_q, prev_a_d, prev_b_q, prev_b_d;
  logic [AW-1:0]       held_a_q, held_a_d, held_b_q, held_b_d;
  logic                tick, start_item, st_we;

  assign tick       = a_vld_q && (a_kind_q == KIND_TICK);
  assign start_item = a_vld_q && (a_kind_q == KIND_START);
  assign st_we      = tick && rec_q;
  assign wp_inc     = wp_q + PW'(1);

  always_comb begin
    rec_d    = rec_q;
    wp_d     = wp_q;
    prev_a_d = prev_a_q;
    prev_b_d = prev_b_q;
    held_a_d = held_a_q;
    held_b_d = held_b_q;
    if (start_item) begin
      rec_d = 1'b1;
      wp_d  = '0;
    end else if (st_we) begin
      wp_d = wp_inc;
      if (wp_inc >= RecLenP) begin
        rec_d = 1'b0;
      end
    end else if (tick) begin
      // A grain picks up a new start index when its offset wraps around.
      if (a_oa_q < prev_a_q) begin
        held_a_d = a_start_q;
      end
      if (a_ob_q < prev_b_q) begin
        held_b_d = a_start_q;
      end
      prev_a_d = a_oa_q;
      prev_b_d = a_ob_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      rec_q    <= 1'b0;
      wp_q     <= '0;
      prev_a_q <= '0;
      prev_b_q <= '0;
      held_a_q <= '0;
      held_b_q <= '0;
    end else begin
      a_vld_q  <= accept;
      rec_q    <= rec_d;
      wp_q     <= wp_d;
      prev_a_q <= prev_a_d;
      prev_b_q <= prev_b_d;
      held_a_q <= held_a_d;
      held_b_q <= held_b_d;
    end
  end

  logic              c_vld_q, c_rec_q;
  logic [SYNC_W-1:0] c_sync_q;
  logic [AW:0]       c_sum_a_q, c_sum_b_q;
  logic [OW-1:0]     c_oa_q, c_ob_q;

  always_ff @(posedge clk_i) begin
    c_rec_q   <= rec_q;
    c_sync_q  <= rec_q ? SYNC_W'(wp_inc) : SYNC_W'(a_start_q);
    c_sum_a_q <= {1'b0, held_a_d} + (AW + 1)'(a_oa_q);
    c_sum_b_q <= {1'b0, held_b_d} + (AW + 1)'(a_ob_q);
    c_oa_q    <= a_oa_q;
    c_ob_q    <= a_ob_q;
  end

  // ---------------- read stage: wrap addresses, read RAM and ROM ----------------
  logic [AW:0]   wrap_a, wrap_b;
  logic [AW-1:0] addr_a, addr_b;

  assign wrap_a = (c_sum_a_q >= RecLenS) ? (c_sum_a_q - RecLenS) : c_sum_a_q;
  assign wrap_b = (c_sum_b_q >= RecLenS) ? (c_sum_b_q - RecLenS) : c_sum_b_q;
  assign addr_a = wrap_a[AW-1:0];
  assign addr_b = wrap_b[AW-1:0];

  logic signed [SAMPLE_W-1:0] smp_a, smp_b;
  logic [WIN_W-1:0]           win_a, win_b;

  dgsp_store #(
    .RECORD_LEN (RECORD_LEN)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (st_we),
    .wr_addr_i   (wp_q[AW-1:0]),
    .wr_data_i   (a_sample_q),
    .rd_addr_a_i (addr_a),
    .rd_addr_b_i (addr_b),
    .rd_data_a_o (smp_a),
    .rd_data_b_o (smp_b)
  );

  dgsp_window #(
    .GRAIN_LEN (GRAIN_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .idx_a_i (c_oa_q),
    .idx_b_i (c_ob_q),
    .win_a_o (win_a),
    .win_b_o (win_b)
  );

  logic              d_vld_q, d_rec_q;
  logic [SYNC_W-1:0] d_sync_q;

  always_ff @(posedge clk_i) begin
    d_rec_q  <= c_rec_q;
    d_sync_q <= c_sync_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      c_vld_q <= tick;
      d_vld_q <= c_vld_q;
    end
  end

  // ---------------- weight stage: sample times window into the queue ----------------
  logic signed [SAMPLE_W+WIN_W:0] prod_a, prod_b;
  result_t                        res;

  assign prod_a = smp_a * $signed({1'b0, win_a});
  assign prod_b = smp_b * $signed({1'b0, win_b});

  always_comb begin
    res.sync  = d_sync_q;
    res.left  = d_rec_q ? '0 : prod_a[SAMPLE_W+WIN_W-1:WIN_W];
    res.right = d_rec_q ? '0 : prod_b[SAMPLE_W+WIN_W-1:WIN_W];
  end

  result_t    head;
  fifo_stat_t fstat;
  logic       pop;

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  dgsp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (d_vld_q),
    .push_data_i (res),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fstat)
  );

  assign m_axis_tvalid_o = !fstat.empty;
  assign m_axis_tdata_o  = {(OUT_DATA_W - $bits(result_t))'(0), head};

  // Items accepted and not yet taken out (start items leave at the state stage).
  logic [CW-1:0] used_q, used_d;

  assign used_d = used_q + CW'(accept) - CW'(pop) - CW'(start_item);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign s_axis_tready_o = (used_q < CW'(FIFO_DEPTH));

  // ---------------- checks ----------------
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(FIFO_DEPTH))
    else $error("in-flight item count exceeds queue depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> !fstat.full || pop)
    else $error("result pushed into a full queue");

  a_rec_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rec_q) |-> wp_q == RecLenP)
    else $error("recording ended before the last address was written");

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_q |-> wp_q < RecLenP)
    else $error("write pointer out of range while recording");

endmodule

`default_nettype wire

/* bench/dgsp_checker.sv */
module dgsp_checker #(
  parameter int unsigned RECORD_LEN = 88200,
  parameter int unsigned GRAIN_LEN  = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  input  wire                                in_ready_i,
  // audio_in [23:0], main_phase [39:24], grain_phase [55:40]
  input  wire  [dgsp_pkg::IN_DATA_W-1:0]     in_data_i,
  // kind
  input  wire                                in_kind_i,
  input  wire                                out_valid_i,
  input  wire                                out_ready_i,
  // left_out [23:0], right_out [47:24], sync_out [64:48], zeros [71:65]
  input  wire  [dgsp_pkg::OUT_DATA_W-1:0]    out_data_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);
  import dgsp_pkg::*;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int unsigned     PAD_LSB = SYNC_W + 2 * SAMPLE_W;

  logic signed [SAMPLE_W-1:0] sample_mem [RECORD_LEN];
  logic        [WIN_W-1:0]    window_mem [GRAIN_LEN];

  bit          recording;
  int unsigned wr_ptr;
  int unsigned last_off_a;
  int unsigned last_off_b;
  int unsigned grain_start_a;
  int unsigned grain_start_b;

  result_t grain_out_q [$];

  // Half-sine window entry in Q0.16, evaluated as a Taylor series in Q2.30
  // on the angle folded into the first quarter period.
  function automatic logic [WIN_W-1:0] half_sine_entry(int unsigned idx);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned n;
    bit              subtract;
    r = idx;
    if (2 * r > GRAIN_LEN) begin
      r = GRAIN_LEN - r;
    end
    x        = (PI_Q30 * r) / GRAIN_LEN;
    x2       = (x * x) >> 30;
    term     = x;
    acc      = x;
    n        = 2;
    subtract = 1'b1;
    while (term != 0) begin
      term = ((term * x2) >> 30) / (n * (n + 1));
      n    = n + 2;
      if (subtract) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
      subtract = !subtract;
    end
    acc = (acc + 8192) >> 14;
    if (acc > 65535) begin
      acc = 65535;
    end
    return acc[WIN_W-1:0];
  endfunction

  // Signed sample times unsigned window, floored back to Q1.23.
  function automatic logic signed [SAMPLE_W-1:0] window_scale(
    logic signed [SAMPLE_W-1:0] smp,
    logic        [WIN_W-1:0]    win
  );
    longint prod;
    longint win_ext;
    win_ext = win;
    prod    = smp * win_ext;
    prod    = prod >>> 16;
    return prod[SAMPLE_W-1:0];
  endfunction

  function automatic void sampler_step(logic kind, logic [IN_DATA_W-1:0] data);
    logic signed [SAMPLE_W-1:0] audio;
    logic        [PHASE_W-1:0]  main_ph;
    logic        [PHASE_W-1:0]  grain_ph;
    logic        [PHASE_W-1:0]  grain_ph_b;
    longint unsigned            start_idx;
    longint unsigned            off_a;
    longint unsigned            off_b;
    longint unsigned            addr_a;
    longint unsigned            addr_b;
    result_t                    res;
    audio    = data[SAMPLE_W-1:0];
    main_ph  = data[SAMPLE_W +: PHASE_W];
    grain_ph = data[SAMPLE_W+PHASE_W +: PHASE_W];
    res      = '0;

    if (kind == KIND_START) begin
      wr_ptr    = 0;
      recording = 1'b1;
      return;
    end

    if (recording) begin
      if (wr_ptr < RECORD_LEN) begin
        sample_mem[wr_ptr] = audio;
      end
      wr_ptr = wr_ptr + 1;
      if (wr_ptr >= RECORD_LEN) begin
        recording = 1'b0;
      end
      res.sync = SYNC_W'(wr_ptr);
      grain_out_q.push_back(res);
      return;
    end

    grain_ph_b = grain_ph + PHASE_HALF;
    start_idx  = (64'(main_ph) * RECORD_LEN) >> 16;
    off_a      = (64'(grain_ph) * GRAIN_LEN) >> 16;
    off_b      = (64'(grain_ph_b) * GRAIN_LEN) >> 16;

    // A grain picks up a new start point only when its offset wraps.
    if (off_a < last_off_a) begin
      grain_start_a = int'(start_idx);
    end
    last_off_a = int'(off_a);
    if (off_b < last_off_b) begin
      grain_start_b = int'(start_idx);
    end
    last_off_b = int'(off_b);

    addr_a    = (grain_start_a + off_a) % RECORD_LEN;
    addr_b    = (grain_start_b + off_b) % RECORD_LEN;
    res.left  = window_scale(sample_mem[addr_a], window_mem[off_a % GRAIN_LEN]);
    res.right = window_scale(sample_mem[addr_b], window_mem[off_b % GRAIN_LEN]);
    res.sync  = SYNC_W'(start_idx);
    grain_out_q.push_back(res);
  endfunction

  initial begin
    for (int i = 0; i < GRAIN_LEN; i++) begin
      window_mem[i] = half_sine_entry(i);
    end
    for (int i = 0; i < RECORD_LEN; i++) begin
      sample_mem[i] = '0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      recording     = 1'b0;
      wr_ptr        = 0;
      last_off_a    = 0;
      last_off_b    = 0;
      grain_start_a = 0;
      grain_start_b = 0;
      grain_out_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        sampler_step(in_kind_i, in_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[PAD_LSB-1:0];
        if (grain_out_q.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d sync_out %0d",
                 got.left, got.right, got.sync);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = grain_out_q.pop_front();
          if (got.left !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, got.left);
            fail_count_o = fail_count_o + 1;
          end
          if (got.right !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, got.right);
            fail_count_o = fail_count_o + 1;
          end
          if (got.sync !== want.sync) begin
            $error("sync_out: expected %0d, got %0d", want.sync, got.sync);
            fail_count_o = fail_count_o + 1;
          end
          if (out_data_i[OUT_DATA_W-1:PAD_LSB] !== '0) begin
            $error("padding: expected 0, got %0h", out_data_i[OUT_DATA_W-1:PAD_LSB]);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
    end
    pending_o = grain_out_q.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  import dgsp_pkg::*;

  localparam int unsigned RECORD_LEN  = 88200;
  localparam int unsigned GRAIN_LEN   = 4096;
  localparam int unsigned CYCLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PLAY_ITEMS  = 700;
  localparam int unsigned REC_ITEMS   = 550;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // Written by the stimulus process only.
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  bit hold_req = 1'b0;

  // Written by the receiver process only.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always #10 clk = ~clk;

  dual_grain_sampler_player #(
    .RECORD_LEN(RECORD_LEN),
    .GRAIN_LEN (GRAIN_LEN)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  dgsp_checker #(
    .RECORD_LEN(RECORD_LEN),
    .GRAIN_LEN (GRAIN_LEN)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .in_kind_i   (s_tuser),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The long hold-off lets the output queue fill so that input gets stalled.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= !(rx_gaps && $urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(kind_e kind, logic [SAMPLE_W-1:0] audio,
                           logic [PHASE_W-1:0] main_ph, logic [PHASE_W-1:0] grain_ph);
    while (tx_gaps && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {grain_ph, main_ph, audio};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [PHASE_W-1:0] grain_acc;
    logic [PHASE_W-1:0] grain_inc;
    logic [PHASE_W-1:0] main_ph;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Playing from the cleared store, phase extremes and both grain wraps.
    send_item(KIND_TICK, 24'h7FFFFF, 16'h0000, 16'h0000);
    send_item(KIND_TICK, 24'h800000, 16'hFFFF, 16'hFFFF);
    send_item(KIND_TICK, 24'hFFFFFF, 16'h8000, 16'h0000);
    send_item(KIND_TICK, 24'h000001, 16'h7FFF, 16'h8000);

    // Playback: mostly a steadily advancing grain phase, some random jumps.
    grain_acc = '0;
    grain_inc = 16'd256;
    main_ph   = 16'hFFFF;
    for (int n = 0; n < PLAY_ITEMS; n++) begin
      if (n == 300) begin
        hold_req = 1'b1;
      end
      if (n == 400) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (n == 650) begin
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
      end
      if (n % 64 == 0) begin
        grain_inc = PHASE_W'($urandom_range(1, 3000));
        main_ph   = PHASE_W'($urandom);
      end
      if ($urandom_range(99) < 80) begin
        grain_acc = grain_acc + grain_inc;
        send_item(KIND_TICK, SAMPLE_W'($urandom), main_ph, grain_acc);
      end else begin
        send_item(KIND_TICK, SAMPLE_W'($urandom), PHASE_W'($urandom),
                  PHASE_W'($urandom));
      end
    end

    // Start item: its data is ignored.
    send_item(KIND_START, 24'h5A5A5A, 16'hFFFF, 16'hFFFF);
    send_item(KIND_TICK, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
    send_item(KIND_TICK, 24'h800000, 16'h0000, 16'h0000);
    send_item(KIND_TICK, 24'h000001, 16'hA5A5, 16'h5A5A);
    send_item(KIND_TICK, 24'hFFFFFF, 16'h5A5A, 16'hA5A5);
    // A start while recording goes back to address zero.
    send_item(KIND_START, 24'hA5A5A5, 16'h0000, 16'h0000);
    send_item(KIND_TICK, 24'h800000, 16'h1234, 16'h4321);

    // Recording with random samples and phases.
    for (int i = 0; i < REC_ITEMS; i++) begin
      send_item(KIND_TICK, rand_sample(), PHASE_W'($urandom), PHASE_W'($urandom));
    end

    // Short recordings, each begun by a restart that cuts off the one before.
    send_item(KIND_START, SAMPLE_W'($urandom), PHASE_W'($urandom), PHASE_W'($urandom));
    for (int i = 0; i < 40; i++) begin
      send_item(KIND_TICK, rand_sample(), PHASE_W'($urandom), PHASE_W'($urandom));
    end
    send_item(KIND_START, SAMPLE_W'($urandom), PHASE_W'($urandom), PHASE_W'($urandom));
    for (int i = 0; i < 25; i++) begin
      send_item(KIND_TICK, rand_sample(), PHASE_W'($urandom), PHASE_W'($urandom));
    end
    s_tvalid <= 1'b0;

    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
